>>> design/ps2_mouse_packet_cursor_tracker_defines.svh
// ----------------------------------------------------------------------------
// ps2 mouse cursor tracker assertion macros
// shared property wrappers, clocked on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_CURSOR_TRACKER_DEFINES_SVH
`define PS2_MOUSE_PACKET_CURSOR_TRACKER_DEFINES_SVH

// same-cycle implication
`define PS2M_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ps2m assertion failed");

// next-cycle implication
`define PS2M_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ps2m assertion failed");

`endif

>>> design/ps2m_pkg.sv
// ----------------------------------------------------------------------------
// ps2m_pkg
// shared types and constants for the ps2 mouse cursor tracker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ps2m_pkg;

    localparam int COORD_BITS = 13;
    localparam int CURSOR_W   = 8;
    localparam int CURSOR_H   = 16;

    localparam int CFG_W     = 14;
    localparam int CFG_IDX_W = 1;
    localparam int DELTA_W   = 10;
    localparam int CALC_W    = ((COORD_BITS > CFG_W) ? COORD_BITS : CFG_W) + 2;

    localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(1024);
    localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(768);
    localparam logic [CFG_W-1:0] MARGIN_X   = CFG_W'(CURSOR_W);
    localparam logic [CFG_W-1:0] MARGIN_Y   = CFG_W'(CURSOR_H);

    localparam logic [7:0] SYNC_MASK = 8'h08;
    localparam int BIT_LEFT   = 0;
    localparam int BIT_RIGHT  = 1;
    localparam int BIT_MIDDLE = 2;
    localparam int BIT_X_SIGN = 4;
    localparam int BIT_Y_SIGN = 5;
    localparam int BIT_X_OVF  = 6;
    localparam int BIT_Y_OVF  = 7;

    localparam logic signed [DELTA_W-1:0] OVF_STEP = DELTA_W'(255);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } ps2m_reg_t;

    typedef enum logic [1:0] {
        PH_STATUS = 2'd0,
        PH_DX     = 2'd1,
        PH_DY     = 2'd2
    } ps2m_phase_t;

    // movement of one axis as carried in a packet
    typedef struct packed {
        logic       neg;
        logic       ovf;
        logic [7:0] mag;
    } ps2m_move_t;

endpackage

>>> design/ps2_mouse_packet_cursor_tracker.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_tracker
// assembles three-byte ps2 mouse packets and tracks a clamped cursor
// ----------------------------------------------------------------------------
// datapath: a byte beat enters the input register, then processing it updates
//   the packet state and loads the result register
// throughput: one byte per cycle; the only stall is a held result beat
// reset: async active low; first byte dropped, phase waits for a status byte,
//   cursor at 0,0, screen 1024 x 768
`timescale 1ns / 1ps

`include "ps2_mouse_packet_cursor_tracker_defines.svh"

module ps2_mouse_packet_cursor_tracker (
    input  logic                               clk,
    input  logic                               rst_n,
    // byte channel
    input  logic                               byte_valid,
    output logic                               byte_stall,
    input  logic [7:0]                         data_byte,
    // result channel
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic [ps2m_pkg::COORD_BITS-1:0]    pos_x,
    output logic [ps2m_pkg::COORD_BITS-1:0]    pos_y,
    output logic                               left_pressed,
    output logic                               middle_pressed,
    output logic                               right_pressed,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ps2m_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ps2m_pkg::CFG_W-1:0]         cfg_data
);
    import ps2m_pkg::*;

    // configuration
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    // input stage
    logic       in_vld_reg;
    logic       in_vld_next;
    logic [7:0] in_byte_reg;

    // packet state
    logic        skip_reg;
    logic        skip_next;
    ps2m_phase_t phase_reg;
    ps2m_phase_t phase_next;
    logic [7:0]  status_reg;
    logic [7:0]  xdelta_reg;
    logic [COORD_BITS-1:0] cursor_x_reg;
    logic [COORD_BITS-1:0] cursor_y_reg;

    // result stage
    logic                  out_vld_reg;
    logic                  out_vld_next;
    logic [COORD_BITS-1:0] pos_x_reg;
    logic [COORD_BITS-1:0] pos_y_reg;
    logic                  left_reg;
    logic                  middle_reg;
    logic                  right_reg;

    // control
    logic byte_take;
    logic advance;
    logic proc_fire;
    logic emit;
    logic cap_status;
    logic cap_xdelta;

    ps2m_move_t            move_x;
    ps2m_move_t            move_y;
    logic [COORD_BITS-1:0] new_x;
    logic [COORD_BITS-1:0] new_y;

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    // the processing stage moves whenever the result register can take a beat
    assign advance    = !out_vld_reg || !result_stall;
    assign proc_fire  = in_vld_reg && advance;
    assign byte_stall = in_vld_reg && !advance;
    assign byte_take  = byte_valid && !byte_stall;

    // registers can be written at any time
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    always_comb
    begin
        if (byte_take)
            in_vld_next = 1'b1;
        else if (proc_fire)
            in_vld_next = 1'b0;
        else
            in_vld_next = in_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= in_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (byte_take)
            in_byte_reg <= data_byte;
    end

    // ------------------------------------------------------------------
    // packet phase: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        skip_next  = skip_reg;
        phase_next = phase_reg;
        if (proc_fire)
        begin
            if (skip_reg)
                skip_next = 1'b0;
            else
            begin
                unique case (phase_reg)
                    PH_STATUS:
                    begin
                        // only a byte with the sync bit opens a packet
                        if ((in_byte_reg & SYNC_MASK) != '0)
                            phase_next = PH_DX;
                    end
                    PH_DX:   phase_next = PH_DY;
                    PH_DY:   phase_next = PH_STATUS;
                    default: phase_next = PH_STATUS;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // packet phase: outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        cap_status = 1'b0;
        cap_xdelta = 1'b0;
        emit       = 1'b0;
        if (proc_fire && !skip_reg)
        begin
            unique case (phase_reg)
                PH_STATUS: cap_status = (in_byte_reg & SYNC_MASK) != '0;
                PH_DX:     cap_xdelta = 1'b1;
                PH_DY:     emit       = 1'b1;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg  <= 1'b1;
            phase_reg <= PH_STATUS;
        end
        else
        begin
            skip_reg  <= skip_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cap_status)
            status_reg <= in_byte_reg;
        if (cap_xdelta)
            xdelta_reg <= in_byte_reg;
    end

    // ------------------------------------------------------------------
    // cursor update, one unit per axis
    // ------------------------------------------------------------------
    assign move_x = '{neg: status_reg[BIT_X_SIGN], ovf: status_reg[BIT_X_OVF],
                      mag: xdelta_reg};
    assign move_y = '{neg: status_reg[BIT_Y_SIGN], ovf: status_reg[BIT_Y_OVF],
                      mag: in_byte_reg};

    ps2m_axis u_axis_x (
        .cur    (cursor_x_reg),
        .move   (move_x),
        .down   (1'b0),
        .extent (width_reg),
        .margin (MARGIN_X),
        .coord  (new_x)
    );

    ps2m_axis u_axis_y (
        .cur    (cursor_y_reg),
        .move   (move_y),
        .down   (1'b1),
        .extent (height_reg),
        .margin (MARGIN_Y),
        .coord  (new_y)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
        end
        else if (emit)
        begin
            cursor_x_reg <= new_x;
            cursor_y_reg <= new_y;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_comb
    begin
        if (emit)
            out_vld_next = 1'b1;
        else if (!result_stall)
            out_vld_next = 1'b0;
        else
            out_vld_next = out_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else
            out_vld_reg <= out_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            pos_x_reg  <= new_x;
            pos_y_reg  <= new_y;
            left_reg   <= status_reg[BIT_LEFT];
            middle_reg <= status_reg[BIT_MIDDLE];
            right_reg  <= status_reg[BIT_RIGHT];
        end
    end

    assign result_valid   = out_vld_reg;
    assign pos_x          = pos_x_reg;
    assign pos_y          = pos_y_reg;
    assign left_pressed   = left_reg;
    assign middle_pressed = middle_reg;
    assign right_pressed  = right_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // the third byte of a packet always yields a result beat
    `PS2M_ASSERT_NEXT(a_third_byte_emits, proc_fire && !skip_reg && phase_reg == PH_DY, out_vld_reg)
    // the dropped first byte is gone after one processed byte
    `PS2M_ASSERT_NEXT(a_skip_once, proc_fire, !skip_reg)
    // a pending result always shows the tracked cursor
    `PS2M_ASSERT_NOW(a_result_is_cursor, out_vld_reg, pos_x_reg == cursor_x_reg && pos_y_reg == cursor_y_reg)
    // the byte side only stalls with a byte held in the input register
    `PS2M_ASSERT_NOW(a_stall_needs_byte, byte_stall, in_vld_reg && out_vld_reg)

endmodule

>>> design/ps2m_axis.sv
// ----------------------------------------------------------------------------
// ps2m_axis
// one axis update: decode the 9-bit delta plus overflow, move and clamp
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ps2m_axis (
    input  logic [ps2m_pkg::COORD_BITS-1:0] cur,
    input  ps2m_pkg::ps2m_move_t            move,
    input  logic                            down,
    input  logic [ps2m_pkg::CFG_W-1:0]      extent,
    input  logic [ps2m_pkg::CFG_W-1:0]      margin,
    output logic [ps2m_pkg::COORD_BITS-1:0] coord
);
    import ps2m_pkg::*;

    localparam logic signed [CALC_W-1:0] TOP = CALC_W'((1 << COORD_BITS) - 1);

    logic signed [DELTA_W-1:0] base;
    logic signed [DELTA_W-1:0] ovf_adj;
    logic signed [DELTA_W-1:0] delta;
    logic signed [CALC_W-1:0]  cur_ext;
    logic signed [CALC_W-1:0]  sum;
    logic signed [CALC_W-1:0]  hi_raw;
    logic signed [CALC_W-1:0]  hi;
    logic signed [CALC_W-1:0]  clamped;

    assign base    = DELTA_W'($signed({move.neg, move.mag}));
    assign ovf_adj = move.ovf ? (move.neg ? -OVF_STEP : OVF_STEP) : '0;
    assign delta   = base + ovf_adj;

    // screen y grows downward, so that axis subtracts
    assign cur_ext = $signed(CALC_W'(cur));
    assign sum     = down ? (cur_ext - CALC_W'(delta)) : (cur_ext + CALC_W'(delta));

    assign hi_raw = $signed(CALC_W'(extent)) - $signed(CALC_W'(margin));

    always_comb
    begin
        if (hi_raw < 0)
            hi = '0;
        else if (hi_raw > TOP)
            hi = TOP;
        else
            hi = hi_raw;

        if (sum < 0)
            clamped = '0;
        else if (sum > hi)
            clamped = hi;
        else
            clamped = sum;
    end

    assign coord = clamped[COORD_BITS-1:0];

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_tracker testbench
// drives raw mouse bytes into the tracker with random gaps and result
// stalls, predicts every cursor beat from its own packet decoder and
// compares each field, across several screen sizes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import ps2m_pkg::*;

    // cycles with no beat on any channel before the run is declared hung;
    // the receiver hold-off below is the longest legal quiet stretch
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    // byte to result passes the input and result registers; margin for bytes that make no result
    localparam int SETTLE_CYCLES   = 8;
    localparam int MAX_GAP         = 19;
    localparam int PHASE_BYTES     = 210;
    localparam int MAX_PRINTED     = 200;

    // one cursor beat as it leaves the block
    typedef struct packed {
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
        logic                  left;
        logic                  middle;
        logic                  right;
    } cursor_beat_t;

    logic                  clk;
    logic                  rst_n;
    logic                  byte_valid;
    logic                  byte_stall;
    logic [7:0]            data_byte;
    logic                  result_valid;
    logic                  result_stall;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic                  left_pressed;
    logic                  middle_pressed;
    logic                  right_pressed;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_data;

    // decoder state kept alongside the block
    logic                  skip_next = 1'b1;
    ps2m_phase_t           phase     = PH_STATUS;
    logic [7:0]            held_status;
    logic [7:0]            held_dx;
    logic [COORD_BITS-1:0] track_x   = '0;
    logic [COORD_BITS-1:0] track_y   = '0;
    logic [CFG_W-1:0]      screen_w  = WIDTH_RST;
    logic [CFG_W-1:0]      screen_h  = HEIGHT_RST;

    cursor_beat_t expected_cursor[$];

    int mismatch_count = 0;
    int idle_cycles    = 0;
    int stall_left     = 0;
    bit tx_burst       = 1'b0;   // sender offers back to back
    bit rx_burst       = 1'b0;   // receiver takes back to back
    bit rx_hold        = 1'b0;   // receiver holds off entirely

    ps2_mouse_packet_cursor_tracker i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_valid     (byte_valid),
        .byte_stall     (byte_stall),
        .data_byte      (data_byte),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .left_pressed   (left_pressed),
        .middle_pressed (middle_pressed),
        .right_pressed  (right_pressed),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // packet decoder and cursor arithmetic
    // ------------------------------------------------------------------------

    // nine-bit two's complement delta, stretched by 255 on overflow
    function automatic int axis_move(input ps2m_move_t mv);
        int d;
        d = int'(mv.mag);
        if (mv.neg)
            d -= 256;
        if (mv.ovf)
            d += mv.neg ? -255 : 255;
        return d;
    endfunction

    // upper bound is screen minus cursor, floored at 0 and capped at the
    // largest coordinate the outputs can carry
    function automatic logic [COORD_BITS-1:0] clamp_axis(input int v,
                                                         input logic [CFG_W-1:0] extent,
                                                         input int margin);
        int hi;
        int top;
        top = (1 << COORD_BITS) - 1;
        hi  = int'(extent) - margin;
        if (hi < 0)
            hi = 0;
        if (hi > top)
            hi = top;
        if (v < 0)
            v = 0;
        if (v > hi)
            v = hi;
        return COORD_BITS'(v);
    endfunction

    // advances the decoder by one accepted byte; returns 1 with the new
    // cursor beat when the byte completes a packet
    function automatic bit track_byte(input logic [7:0] b, output cursor_beat_t beat);
        ps2m_move_t mx;
        ps2m_move_t my;
        beat = '0;
        if (skip_next)
        begin
            skip_next = 1'b0;
            return 1'b0;
        end
        if (phase == PH_STATUS)
        begin
            // stray byte while waiting for a packet start
            if ((b & SYNC_MASK) == 8'h00)
                return 1'b0;
            held_status = b;
            phase       = PH_DX;
            return 1'b0;
        end
        if (phase == PH_DX)
        begin
            held_dx = b;
            phase   = PH_DY;
            return 1'b0;
        end
        phase   = PH_STATUS;
        mx.neg  = held_status[BIT_X_SIGN];
        mx.ovf  = held_status[BIT_X_OVF];
        mx.mag  = held_dx;
        my.neg  = held_status[BIT_Y_SIGN];
        my.ovf  = held_status[BIT_Y_OVF];
        my.mag  = b;
        // screen y grows downward, so the y delta is subtracted
        track_x = clamp_axis(int'(track_x) + axis_move(mx), screen_w, CURSOR_W);
        track_y = clamp_axis(int'(track_y) - axis_move(my), screen_h, CURSOR_H);
        beat.pos_x  = track_x;
        beat.pos_y  = track_y;
        beat.left   = held_status[BIT_LEFT];
        beat.middle = held_status[BIT_MIDDLE];
        beat.right  = held_status[BIT_RIGHT];
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // watching the input side: byte beats feed the decoder, config beats
    // update the screen size it clamps against
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_inputs
        cursor_beat_t beat;
        if (rst_n)
        begin
            if (byte_valid && !byte_stall)
            begin
                if (track_byte(data_byte, beat))
                    expected_cursor.push_back(beat);
            end
            if (cfg_valid && cfg_ready)
            begin
                case (ps2m_reg_t'(cfg_index))
                    REG_WIDTH:  screen_w = cfg_data;
                    REG_HEIGHT: screen_h = cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // result checking, oldest expectation first
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < MAX_PRINTED)
            $display("%0t ns mismatch on %s: got %0d, expected %0d",
                     $realtime, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin : check_results
        cursor_beat_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            // next stall length, drawn per beat; bursts give stall-free stretches
            if ($urandom_range(0, 29) == 0)
                rx_burst = !rx_burst;
            stall_left = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (expected_cursor.size() == 0)
                report_mismatch("unexpected result beat", 32'd1, 32'd0);
            else
            begin
                want = expected_cursor.pop_front();
                if (pos_x !== want.pos_x)
                    report_mismatch("pos_x", 32'(pos_x), 32'(want.pos_x));
                if (pos_y !== want.pos_y)
                    report_mismatch("pos_y", 32'(pos_y), 32'(want.pos_y));
                if (left_pressed !== want.left)
                    report_mismatch("left_pressed", 32'(left_pressed), 32'(want.left));
                if (middle_pressed !== want.middle)
                    report_mismatch("middle_pressed", 32'(middle_pressed), 32'(want.middle));
                if (right_pressed !== want.right)
                    report_mismatch("right_pressed", 32'(right_pressed), 32'(want.right));
            end
        end
    end

    // receiver: waits out the drawn stall before each beat, or holds off
    // completely while a back-pressure test asks for it
    always @(negedge clk)
    begin
        if (rx_hold)
            result_stall <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left   = stall_left - 1;
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    // hang detector: any beat on any channel resets the count
    always @(posedge clk)
    begin
        if ((byte_valid && !byte_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL ps2_mouse_packet_cursor_tracker");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // shared drivers
    // ------------------------------------------------------------------------

    // offers one byte after a random gap and returns once it is taken;
    // valid stays high after the beat until the next call or a drain
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if ($urandom_range(0, 39) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            @(negedge clk);
            byte_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        byte_valid <= 1'b1;
        data_byte  <= b;
        do
            @(posedge clk);
        while (byte_stall !== 1'b0);
    endtask

    task automatic send_packet(input logic [7:0] status, input logic [7:0] dx,
                               input logic [7:0] dy);
        send_byte(status);
        send_byte(dx);
        send_byte(dy);
    endtask

    // sender goes quiet until every predicted beat is out and the pipe is empty
    task automatic wait_for_results();
        @(negedge clk);
        byte_valid <= 1'b0;
        while (expected_cursor.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input ps2m_reg_t idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_screen(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        wait_for_results();
        write_config(REG_WIDTH, w);
        write_config(REG_HEIGHT, h);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // first byte after reset looks like a packet start but must be dropped;
    // bytes without the sync bit are skipped while waiting for a start
    task automatic test_first_byte_and_sync();
        send_byte(8'h08);
        send_byte(8'h37);
        send_byte(8'hF0);
        // left and middle buttons; y runs below zero and clamps
        send_packet(8'h0D, 8'h05, 8'h03);
    endtask

    // buttons, signs, zero magnitude with sign set, overflow both ways,
    // and the all-zero and all-one byte values
    task automatic test_buttons_and_deltas();
        send_packet(8'h3A, 8'h00, 8'h00);
        send_packet(8'h48, 8'hFF, 8'hFF);
        send_packet(8'hFF, 8'h00, 8'h80);
    endtask

    // screen smaller than the cursor forces both axes to 0, then a screen
    // far beyond the coordinate range
    task automatic test_tiny_screen();
        set_screen(CFG_W'(4), CFG_W'(10));
        send_packet(8'h08, 8'h7F, 8'h81);
        set_screen('1, '1);
        send_packet(8'hE8, 8'hFF, 8'h00);
    endtask

    // receiver holds off long enough that the block backs up into the byte
    // channel while the sender keeps offering, then everything drains
    task automatic test_result_backpressure();
        bit keep_burst;
        logic [7:0] st;
        keep_burst = tx_burst;
        tx_burst   = 1'b1;
        fork
            begin
                rx_hold = 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                rx_hold = 1'b0;
            end
            begin
                for (int n = 0; n < 40; n++)
                begin
                    st    = 8'($urandom);
                    st[3] = 1'b1;
                    send_byte(st);
                    send_byte(8'($urandom));
                    send_byte(8'($urandom));
                    tx_burst = 1'b1;
                end
            end
        join
        tx_burst = keep_burst;
        wait_for_results();
    endtask

    // mostly well-formed packets with random content; the first third drifts
    // toward the far corner, the second back toward the origin, so both clamp
    // limits get hit. some packets are cut short and some line noise is mixed in
    task automatic run_random_traffic(input int n_bytes);
        int sent;
        int cut;
        logic [7:0] st;
        sent = 0;
        while (sent < n_bytes)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                st = 8'($urandom);
                if ($urandom_range(0, 2) != 0)
                    st[3] = 1'b0;
                send_byte(st);
                sent++;
            end
            else
            begin
                st    = 8'($urandom);
                st[3] = 1'b1;
                if (sent < n_bytes / 3)
                begin
                    st[BIT_X_SIGN] = 1'b0;
                    st[BIT_Y_SIGN] = 1'b1;
                end
                else if (sent < 2 * n_bytes / 3)
                begin
                    st[BIT_X_SIGN] = 1'b1;
                    st[BIT_Y_SIGN] = 1'b0;
                end
                cut = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 2) : 3;
                send_byte(st);
                if (cut > 1)
                    send_byte(8'($urandom));
                if (cut > 2)
                    send_byte(8'($urandom));
                sent += cut;
            end
        end
    endtask

    task automatic test_random_screens();
        set_screen('1, '1);
        run_random_traffic(PHASE_BYTES);
        set_screen('0, '0);
        run_random_traffic(PHASE_BYTES);
        set_screen(CFG_W'(16), CFG_W'(16));
        run_random_traffic(PHASE_BYTES);
        set_screen(CFG_W'(8192), CFG_W'(8192));
        run_random_traffic(PHASE_BYTES);
        set_screen(CFG_W'($urandom_range(16, 8192)), CFG_W'($urandom_range(16, 8192)));
        run_random_traffic(PHASE_BYTES);
        set_screen(WIDTH_RST, HEIGHT_RST);
        run_random_traffic(PHASE_BYTES);
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        byte_valid   = 1'b0;
        data_byte    = 8'h00;
        cfg_valid    = 1'b0;
        cfg_index    = REG_WIDTH;
        cfg_data     = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        test_first_byte_and_sync();
        test_buttons_and_deltas();
        test_tiny_screen();
        test_result_backpressure();
        test_random_screens();
        wait_for_results();

        if (mismatch_count == 0)
            $display("PASS ps2_mouse_packet_cursor_tracker");
        else
            $display("FAIL ps2_mouse_packet_cursor_tracker");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/ps2m_pkg.sv
design/ps2m_axis.sv
design/ps2_mouse_packet_cursor_tracker.sv
tb/sv/testbench.sv
